// ===== design/dhm_pkg.sv =====
// Shared definitions for the Diffie-Hellman modular exponentiation engine.
// Holds reset values, register indexes and the multiplier status type.
// No dependencies.
package dhm_pkg;

    // Default operand width in bits.
    localparam int KEY_BITS_DEFAULT = 16;

    // Register file reset values.
    localparam logic [31:0] RESET_MODULUS   = 32'd65521;
    localparam logic [31:0] RESET_GENERATOR = 32'd2;
    localparam logic [31:0] RESET_SECRET    = 32'd10000;

    // Configuration bus geometry and register indexes (word addressed).
    localparam int         APB_ADDR_W   = 4;
    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_SECRET   = 2'd2;

    // Status of the serial modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } dhm_mm_status_t;

endpackage

// ===== design/dhm_cfg_regs.sv =====
// APB-style configuration registers: modulus, generator and secret exponent.
// Depends on dhm_pkg for reset values and register indexes.
module dhm_cfg_regs
    import dhm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [KEY_BITS-1:0]   modulus,
    output logic [KEY_BITS-1:0]   generator,
    output logic [KEY_BITS-1:0]   secret_exponent
);

    logic [KEY_BITS-1:0] modulus_reg;
    logic [KEY_BITS-1:0] generator_reg;
    logic [KEY_BITS-1:0] secret_reg;
    logic [KEY_BITS-1:0] wdata;
    logic [KEY_BITS-1:0] modulus_next;
    logic                wr_en;

    // The bus never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[KEY_BITS-1:0];

    // A modulus below two is raised to two so the reduction stays defined.
    assign modulus_next = (wdata < KEY_BITS'(2)) ? KEY_BITS'(2) : wdata;

    // Register writes; writes to unused addresses are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= RESET_MODULUS[KEY_BITS-1:0];
            generator_reg <= RESET_GENERATOR[KEY_BITS-1:0];
            secret_reg    <= RESET_SECRET[KEY_BITS-1:0];
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MODULUS:   modulus_reg   <= modulus_next;
                REG_GENERATOR: generator_reg <= wdata;
                REG_SECRET:    secret_reg    <= wdata;
                default:       ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (paddr[3:2])
            REG_MODULUS:   prdata = 32'(modulus_reg);
            REG_GENERATOR: prdata = 32'(generator_reg);
            REG_SECRET:    prdata = 32'(secret_reg);
            default:       prdata = '0;
        endcase
    end

    assign modulus         = modulus_reg;
    assign generator       = generator_reg;
    assign secret_exponent = secret_reg;

endmodule

// ===== design/dhm_mulmod.sv =====
// Bit-serial interleaved modular multiplier: product = a * b mod m.
// Takes one bit of a per cycle, MSB first; b must already be below m.
// Depends on dhm_pkg for the status type.
module dhm_mulmod
    import dhm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [KEY_BITS-1:0] op_a,
    input  logic [KEY_BITS-1:0] op_b,
    input  logic [KEY_BITS-1:0] op_m,
    output logic [KEY_BITS-1:0] product,
    output dhm_mm_status_t      status
);

    localparam int CNT_W = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] a_sh_reg;
    logic [KEY_BITS-1:0] b_reg;
    logic [KEY_BITS-1:0] m_reg;
    logic [KEY_BITS-1:0] r_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [KEY_BITS:0]   dbl;
    logic [KEY_BITS:0]   sum;
    logic [KEY_BITS+1:0] diff1;
    logic [KEY_BITS+1:0] diff2;
    logic [KEY_BITS-1:0] r_dbl;
    logic [KEY_BITS-1:0] r_next;

    // One step: double and reduce, then add b when the bit is set and reduce again.
    // Both partial values stay below 2m, so one conditional subtract each suffices.
    always_comb
    begin
        dbl    = {r_reg, 1'b0};
        diff1  = {1'b0, dbl} - {2'b00, m_reg};
        r_dbl  = diff1[KEY_BITS+1] ? dbl[KEY_BITS-1:0] : diff1[KEY_BITS-1:0];
        sum    = {1'b0, r_dbl} + (a_sh_reg[KEY_BITS-1] ? {1'b0, b_reg} : '0);
        diff2  = {1'b0, sum} - {2'b00, m_reg};
        r_next = diff2[KEY_BITS+1] ? sum[KEY_BITS-1:0] : diff2[KEY_BITS-1:0];
    end

    // Control: bit counter, busy flag and a one-cycle completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg  <= CNT_W'(KEY_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand capture, multiplier shift register and partial remainder.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_sh_reg <= op_a;
            b_reg    <= op_b;
            m_reg    <= op_m;
            r_reg    <= '0;
        end
        else if (busy_reg)
        begin
            a_sh_reg <= {a_sh_reg[KEY_BITS-2:0], 1'b0};
            r_reg    <= r_next;
        end
    end

    assign product     = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== design/dh_modular_exponentiation.sv =====
// Diffie-Hellman modular exponentiation engine, top level.
// Holds the square-and-multiply sequencer; uses dhm_cfg_regs and dhm_mulmod.
// Depends on dhm_pkg.
//
// Usage:
//   Configure modulus, generator and secret exponent over the APB port
//   (byte addresses 0, 4 and 8) while busy is low. Raise start with action
//   and remote_key; the request is taken on a clock edge with busy low.
//   action 0 returns generator^secret mod modulus, action 1 returns
//   remote_key^secret mod modulus.
//   The key appears on key_value with done high for exactly one cycle; the
//   receiver cannot hold it off. busy falls in that same cycle, so a new
//   request may be taken there.
//   The engine uses the single bit-serial modular multiplier for one reduction
//   of the base, one multiply per set exponent bit and KEY_BITS-1 squarings;
//   each round also passes through the S_ROUND and S_SQ bookkeeping states.
//   One request is in flight at a time.
//   Reset returns the registers to 65521, 2 and 10000 and the engine to idle.
module dh_modular_exponentiation
    import dhm_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [KEY_BITS-1:0]   remote_key,
    output logic                  done,
    output logic [KEY_BITS-1:0]   key_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int RND_W = $clog2(KEY_BITS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED_W = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_MUL_W = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_SQ_W  = 3'd5;

    logic [KEY_BITS-1:0] cfg_modulus;
    logic [KEY_BITS-1:0] cfg_generator;
    logic [KEY_BITS-1:0] cfg_secret;

    logic [2:0]          state_reg;
    logic [KEY_BITS-1:0] acc_reg;
    logic [KEY_BITS-1:0] sq_reg;
    logic [KEY_BITS-1:0] exp_reg;
    logic [RND_W-1:0]    round_reg;
    logic [KEY_BITS-1:0] op_a_reg;
    logic [KEY_BITS-1:0] op_b_reg;
    logic                go_reg;
    logic                done_reg;
    logic [KEY_BITS-1:0] key_reg;

    logic [KEY_BITS-1:0] mm_product;
    dhm_mm_status_t      mm_status;
    logic                last_round;

    dhm_cfg_regs #(
        .KEY_BITS (KEY_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .modulus         (cfg_modulus),
        .generator       (cfg_generator),
        .secret_exponent (cfg_secret)
    );

    dhm_mulmod #(
        .KEY_BITS (KEY_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .op_m    (cfg_modulus),
        .product (mm_product),
        .status  (mm_status)
    );

    assign last_round = (round_reg == RND_W'(KEY_BITS - 1));

    // Control: state, multiplier launch pulse and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        go_reg    <= 1'b1;
                        state_reg <= S_RED_W;
                    end
                end
                S_RED_W:
                begin
                    if (mm_status.done)
                    begin
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    if (exp_reg[0])
                    begin
                        go_reg    <= 1'b1;
                        state_reg <= S_MUL_W;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_MUL_W:
                begin
                    if (mm_status.done)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (last_round)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        go_reg    <= 1'b1;
                        state_reg <= S_SQ_W;
                    end
                end
                S_SQ_W:
                begin
                    if (mm_status.done)
                    begin
                        round_reg <= round_reg + RND_W'(1);
                        state_reg <= S_ROUND;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: operand selection, accumulator, running square and exponent.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                // Reduce the base first so every later operand is below the modulus.
                op_a_reg <= action ? remote_key : cfg_generator;
                op_b_reg <= KEY_BITS'(1);
                acc_reg  <= KEY_BITS'(1);
                exp_reg  <= cfg_secret;
            end
            S_RED_W:
            begin
                if (mm_status.done)
                begin
                    sq_reg <= mm_product;
                end
            end
            S_ROUND:
            begin
                op_a_reg <= acc_reg;
                op_b_reg <= sq_reg;
            end
            S_MUL_W:
            begin
                if (mm_status.done)
                begin
                    acc_reg <= mm_product;
                end
            end
            S_SQ:
            begin
                op_a_reg <= sq_reg;
                op_b_reg <= sq_reg;
                key_reg  <= acc_reg;
            end
            S_SQ_W:
            begin
                if (mm_status.done)
                begin
                    sq_reg  <= mm_product;
                    exp_reg <= {1'b0, exp_reg[KEY_BITS-1:1]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign key_value = key_reg;

    // A delivered key is always reduced below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (key_value < cfg_modulus))
        else $error("key_value not reduced below modulus");

    // The multiplier only completes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> (state_reg == S_RED_W || state_reg == S_MUL_W
                            || state_reg == S_SQ_W))
        else $error("multiplier completed outside a wait state");

    // An accepted request makes the engine busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start the engine");

    // A launch is never issued while the multiplier is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> !mm_status.busy)
        else $error("multiplier launched while busy");

endmodule
